// ----- hdl/plf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_pkg
// shared types, letter codes and key square reset values for the playfair unit
// ----------------------------------------------------------------------------
package plf_pkg;

	localparam int GRID_DIM  = 5;
	localparam int LETTER_W  = 5;
	localparam int IDX_W     = $clog2(GRID_DIM);
	localparam int ROW_W     = GRID_DIM * LETTER_W;
	localparam int CFG_IDX_W = 3;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef letter_t [GRID_DIM-1:0] row_t;
	typedef row_t [GRID_DIM-1:0] key_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// letter codes
	localparam letter_t CODE_I = letter_t'(8);
	localparam letter_t CODE_J = letter_t'(9);
	localparam letter_t CODE_Q = letter_t'(16);
	localparam letter_t CODE_X = letter_t'(23);
	localparam letter_t CODE_Z = letter_t'(25);

	// register indexes
	localparam cfg_idx_t REG_KEY_ROW_0 = cfg_idx_t'(0);
	localparam cfg_idx_t REG_KEY_ROW_1 = cfg_idx_t'(1);
	localparam cfg_idx_t REG_KEY_ROW_2 = cfg_idx_t'(2);
	localparam cfg_idx_t REG_KEY_ROW_3 = cfg_idx_t'(3);
	localparam cfg_idx_t REG_KEY_ROW_4 = cfg_idx_t'(4);

	// square A B C D E / F G H I K / L M N O P / Q R S T U / V W X Y Z
	localparam row_t KEY_ROW_0_RST = row_t'(25'd4294688);
	localparam row_t KEY_ROW_1_RST = row_t'(25'd10755269);
	localparam row_t KEY_ROW_2_RST = row_t'(25'd16201099);
	localparam row_t KEY_ROW_3_RST = row_t'(25'd21613104);
	localparam row_t KEY_ROW_4_RST = row_t'(25'd27025109);

	typedef struct packed {
		letter_t first;
		letter_t second;
	} pair_t;

	// one or two digraphs formed by one accepted item
	typedef struct packed {
		pair_t [1:0] pairs;
		logic        two;
		logic        mode;
		logic        eom;
	} job_t;

	// ciphered letters of one item, in output order
	typedef struct packed {
		letter_t [3:0] letters;
		logic          two;
		logic          eom;
	} burst_t;

	typedef struct packed {
		logic    valid;
		letter_t letter;
	} pend_t;

endpackage

// ----- hdl/plf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_if
// handshake channels of the playfair unit: letters in, cipher letters out, config
// ----------------------------------------------------------------------------
interface plf_in_if;
	logic              valid;
	logic              ready;
	plf_pkg::letter_t  letter;
	logic              mode;
	logic              end_of_message;

	modport source (output valid, letter, mode, end_of_message, input ready);
	modport sink (input valid, letter, mode, end_of_message, output ready);
endinterface

interface plf_out_if;
	logic              valid;
	logic              ready;
	plf_pkg::letter_t  cipher_letter;
	logic              last_of_run;
	logic              message_done;

	modport source (output valid, cipher_letter, last_of_run, message_done, input ready);
	modport sink (input valid, cipher_letter, last_of_run, message_done, output ready);
endinterface

interface plf_cfg_if;
	logic                  valid;
	logic                  ready;
	plf_pkg::cfg_idx_t     index;
	logic [plf_pkg::ROW_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/plf_pair.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_pair
// input stage: j to i mapping, pending letter, filler and padding, digraph register
// ----------------------------------------------------------------------------
module plf_pair (
	input  logic            clk,
	input  logic            arst_n,
	plf_in_if.sink          din,
	input  logic            job_ready,
	output logic            job_valid_s1,
	output plf_pkg::job_t   job_s1,
	output plf_pkg::pend_t  pend
);

	plf_pkg::letter_t pend_letter_q;
	logic             pend_valid_q;
	plf_pkg::letter_t nxt_letter;
	logic             nxt_valid;
	plf_pkg::job_t    job_d;
	logic [1:0]       npairs;
	logic             accept;

	assign din.ready   = !job_valid_s1 || job_ready;
	assign accept      = din.valid && din.ready;
	assign pend.valid  = pend_valid_q;
	assign pend.letter = pend_letter_q;

	always_comb begin
		plf_pkg::letter_t l;
		l          = (din.letter == plf_pkg::CODE_J) ? plf_pkg::CODE_I : din.letter;
		nxt_letter = pend_letter_q;
		nxt_valid  = pend_valid_q;
		job_d      = '0;
		npairs     = 2'd0;
		if (pend_valid_q) begin
			job_d.pairs[0].first = pend_letter_q;
			if (l != pend_letter_q) begin
				job_d.pairs[0].second = l;
				nxt_valid             = 1'b0;
			end else begin
				// doubled letter: filler, the letter stays pending
				job_d.pairs[0].second = (pend_letter_q == plf_pkg::CODE_X) ?
				                        plf_pkg::CODE_Q : plf_pkg::CODE_X;
				nxt_letter            = l;
			end
			npairs = 2'd1;
		end else begin
			nxt_letter = l;
			nxt_valid  = 1'b1;
		end
		if (din.end_of_message) begin
			if (nxt_valid) begin
				job_d.pairs[npairs[0]].first  = nxt_letter;
				job_d.pairs[npairs[0]].second = (nxt_letter == plf_pkg::CODE_Z) ?
				                                plf_pkg::CODE_X : plf_pkg::CODE_Z;
				npairs = npairs + 2'd1;
			end
			nxt_valid  = 1'b0;
			nxt_letter = '0;
		end
		job_d.two  = npairs[1];
		job_d.mode = din.mode;
		job_d.eom  = din.end_of_message;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q  <= 1'b0;
			pend_letter_q <= '0;
			job_valid_s1  <= 1'b0;
		end else begin
			if (accept) begin
				pend_valid_q  <= nxt_valid;
				pend_letter_q <= nxt_letter;
				job_valid_s1  <= (npairs != 2'd0);
			end else if (job_ready) begin
				job_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
		end
	end

endmodule

// ----- hdl/plf_digraph.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_digraph
// enciphers or deciphers one digraph against the 5x5 key square
// ----------------------------------------------------------------------------
module plf_digraph (
	input  plf_pkg::key_t                  key,
	input  plf_pkg::pair_t                 pair,
	input  logic                           decrypt,
	output plf_pkg::letter_t [1:0]         cipher
);

	typedef struct packed {
		plf_pkg::idx_t row;
		plf_pkg::idx_t col;
	} loc_t;

	// first match in row-major order, row 0 column 0 when absent
	function automatic loc_t locate(plf_pkg::key_t k, plf_pkg::letter_t code);
		loc_t loc;
		logic found;
		loc   = '0;
		found = 1'b0;
		for (int r = 0; r < plf_pkg::GRID_DIM; r++) begin
			for (int c = 0; c < plf_pkg::GRID_DIM; c++) begin
				if (!found && k[r][c] == code) begin
					loc.row = plf_pkg::idx_t'(r);
					loc.col = plf_pkg::idx_t'(c);
					found   = 1'b1;
				end
			end
		end
		return loc;
	endfunction

	function automatic plf_pkg::idx_t step(plf_pkg::idx_t v, logic dec);
		plf_pkg::idx_t res;
		if (dec) begin
			res = (v == '0) ? plf_pkg::idx_t'(plf_pkg::GRID_DIM - 1) : v - 1'b1;
		end else begin
			res = (v == plf_pkg::idx_t'(plf_pkg::GRID_DIM - 1)) ? '0 : v + 1'b1;
		end
		return res;
	endfunction

	loc_t a, b, a_n, b_n;

	always_comb begin
		a   = locate(key, pair.first);
		b   = locate(key, pair.second);
		a_n = a;
		b_n = b;
		if (a.row == b.row) begin
			a_n.col = step(a.col, decrypt);
			b_n.col = step(b.col, decrypt);
		end else if (a.col == b.col) begin
			a_n.row = step(a.row, decrypt);
			b_n.row = step(b.row, decrypt);
		end else begin
			a_n.col = b.col;
			b_n.col = a.col;
		end
		cipher[0] = key[a_n.row][a_n.col];
		cipher[1] = key[b_n.row][b_n.col];
	end

endmodule

// ----- hdl/plf_burst.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_burst
// result register holding up to four cipher letters, sent one per beat
// ----------------------------------------------------------------------------
module plf_burst (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_valid,
	input  plf_pkg::burst_t  load,
	output logic             load_ready,
	plf_out_if.source        dout
);

	localparam logic [1:0] LAST_ONE = 2'd1;
	localparam logic [1:0] LAST_TWO = 2'd3;

	plf_pkg::letter_t [3:0] buf_q;
	logic                   buf_valid_q;
	logic [1:0]             idx_q;
	logic                   two_q;
	logic                   eom_q;
	logic                   last;
	logic                   take;
	logic                   fill;

	assign last       = idx_q == (two_q ? LAST_TWO : LAST_ONE);
	assign take       = dout.valid && dout.ready;
	assign load_ready = !buf_valid_q || (take && last);
	assign fill       = load_valid && load_ready;

	assign dout.valid         = buf_valid_q;
	assign dout.cipher_letter = buf_q[idx_q];
	assign dout.last_of_run   = last;
	assign dout.message_done  = last && eom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (fill) begin
				buf_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (take) begin
				buf_valid_q <= !last;
				idx_q       <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill) begin
			buf_q <= load.letters;
			two_q <= load.two;
			eom_q <= load.eom;
		end
	end

endmodule

// ----- hdl/playfair_digraph_cipher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit
// playfair 5x5 digraph cipher over a stream of letters
// ----------------------------------------------------------------------------
// Letters (A=0..Z=25, J read as I) enter on din one per beat and pair up into
// digraphs; doubled letters get an X filler (Q after X) and the last letter of
// a message is padded with Z (X after Z). Each item yields 0, 2 or 4 cipher
// letters on dout, in order, one per beat. An item is taken every cycle as
// long as the result side keeps up: the input register and the result
// register are separate, so a new item is taken while the letters of the one
// before are still being sent. The result port moves one letter per cycle
// while dout is ready, so with sustained input items are taken only as fast
// as their letters leave. The first letter of an item passes the digraph
// register and then the result register before it is on dout. The key square
// lives in five 25-bit row registers written through cfg (index 0..4, column
// 0 in the low bits); writes are to be made only while the unit is idle.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	plf_in_if.sink      din,
	plf_out_if.source   dout,
	plf_cfg_if.sink     cfg
);

	// key square row registers
	plf_pkg::key_t   key_q;

	// digraph register between pairing and cipher lookup
	logic            job_valid_s1;
	plf_pkg::job_t   job_s1;
	logic            job_ready;
	plf_pkg::pend_t  pend;

	// cipher letters of the two digraphs
	plf_pkg::letter_t [1:0] ciph0;
	plf_pkg::letter_t [1:0] ciph1;
	plf_pkg::burst_t        burst;

	// config always accepted
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= plf_pkg::KEY_ROW_0_RST;
			key_q[1] <= plf_pkg::KEY_ROW_1_RST;
			key_q[2] <= plf_pkg::KEY_ROW_2_RST;
			key_q[3] <= plf_pkg::KEY_ROW_3_RST;
			key_q[4] <= plf_pkg::KEY_ROW_4_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				plf_pkg::REG_KEY_ROW_0: key_q[0] <= plf_pkg::row_t'(cfg.data);
				plf_pkg::REG_KEY_ROW_1: key_q[1] <= plf_pkg::row_t'(cfg.data);
				plf_pkg::REG_KEY_ROW_2: key_q[2] <= plf_pkg::row_t'(cfg.data);
				plf_pkg::REG_KEY_ROW_3: key_q[3] <= plf_pkg::row_t'(cfg.data);
				plf_pkg::REG_KEY_ROW_4: key_q[4] <= plf_pkg::row_t'(cfg.data);
				default: ;
			endcase
		end
	end

	// pairing front end with pending letter
	plf_pair u_pair (
		.clk          (clk),
		.arst_n       (arst_n),
		.din          (din),
		.job_ready    (job_ready),
		.job_valid_s1 (job_valid_s1),
		.job_s1       (job_s1),
		.pend         (pend)
	);

	// first digraph of the item
	plf_digraph u_dg0 (
		.key     (key_q),
		.pair    (job_s1.pairs[0]),
		.decrypt (job_s1.mode),
		.cipher  (ciph0)
	);

	// padding digraph after a doubled last letter
	plf_digraph u_dg1 (
		.key     (key_q),
		.pair    (job_s1.pairs[1]),
		.decrypt (job_s1.mode),
		.cipher  (ciph1)
	);

	always_comb begin
		burst.letters[0] = ciph0[0];
		burst.letters[1] = ciph0[1];
		burst.letters[2] = ciph1[0];
		burst.letters[3] = ciph1[1];
		burst.two        = job_s1.two;
		burst.eom        = job_s1.eom;
	end

	// result register and letter serializer
	plf_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (job_valid_s1),
		.load       (burst),
		.load_ready (job_ready),
		.dout       (dout)
	);

`ifndef SYNTH
	// end of message always leaves nothing pending
	a_eom_clears: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready && din.end_of_message |=> !pend.valid)
		else $error("pending letter survived end of message");

	// message done only on the closing letter of a run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.message_done |-> dout.last_of_run)
		else $error("message done without last of run");

	// a digraph waiting on the result register is held
	a_job_hold: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_s1 && !job_ready |=> job_valid_s1 && $stable(job_s1))
		else $error("stalled digraph lost or changed");

	// key square changes only on a config beat
	a_key_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.valid |=> $stable(key_q))
		else $error("key square changed without a write");
`endif

endmodule
